FILE: src/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;
    localparam int STATUS_W = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

FILE: src/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_prev_ins,
    input  spq_pkg::t_entry    i_prev_entry,
    input  spq_pkg::t_entry    i_next_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_ins
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // The new entry belongs at or before this cell when the cell is empty or
    // holds a strictly lower priority, so equal priorities keep their order.
    assign o_ins = !i_occupied || (i_ctl.new_entry.prio > r_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq && o_ins) begin
            n_entry = i_prev_ins ? i_prev_entry : i_ctl.new_entry;
        end else if (i_ctl.deq) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: src/sorted_priority_queue_top.sv
// Sorted priority queue built as a row of DEPTH cells, highest priority in
// cell zero. Each input transfer carries a command: enqueue stores the data
// word and priority behind all entries of equal or higher priority, dequeue
// removes the head entry and returns it. Every input transfer produces
// exactly one result transfer with a status, the removed entry on a
// successful dequeue, and the occupancy after the operation.
// The capacity register (APB, address 0) limits how many entries are held;
// values above DEPTH are limited to DEPTH.
// The result is registered: result valid rises in the cycle after the input
// transfer. All cells shift or insert in parallel, so one item is taken
// every cycle as long as the result register is taken too; the single output
// register sets that rate. When the receiver stalls, the result waits in the
// output register and the input ready stays low until it is taken.
// Reset empties the queue, clears the result valid flag and sets the capacity
// to 16. Cell contents are not cleared; only cells below the count are read.
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spq_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [spq_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [spq_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_command,
    input  logic signed [spq_pkg::DATA_W-1:0]    i_item_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]    i_item_priority,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [spq_pkg::STATUS_W-1:0]         o_status,
    output logic signed [spq_pkg::DATA_W-1:0]    o_head_data,
    output logic signed [spq_pkg::PRIO_W-1:0]    o_head_priority,
    output logic [spq_pkg::OCC_W-1:0]            o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;
    localparam logic [CMPW-1:0] DEPTH_EXT = CMPW'(DEPTH);

    logic [spq_pkg::CAP_W-1:0] r_capacity;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_out_valid;
    logic [spq_pkg::STATUS_W-1:0] r_status;
    logic [spq_pkg::STATUS_W-1:0] n_status;
    spq_pkg::t_entry           r_head;
    spq_pkg::t_entry           n_head;
    logic [spq_pkg::OCC_W-1:0] r_occupancy;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [CMPW-1:0]           count_ext;
    logic [CMPW-1:0]           n_count_ext;
    spq_pkg::t_cell_ctl        ctl;
    spq_pkg::t_entry           cell_entry [DEPTH];
    logic                      cell_ins [DEPTH];

    assign pready = 1'b1;
    assign prdata = spq_pkg::APB_DATA_W'(r_capacity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= spq_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr == spq_pkg::ADDR_CAPACITY) begin
            r_capacity <= pwdata[spq_pkg::CAP_W-1:0];
        end
    end

    assign accept = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign count_ext = CMPW'(r_count);
    assign full = (count_ext >= CMPW'(r_capacity)) || (count_ext >= DEPTH_EXT);
    assign empty = (r_count == '0);

    always_comb begin
        ctl.enq = accept && (i_command == spq_pkg::CMD_ENQ) && !full;
        ctl.deq = accept && (i_command == spq_pkg::CMD_DEQ) && !empty;
        ctl.new_entry.data = i_item_data;
        ctl.new_entry.prio = i_item_priority;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic            occupied;
        logic            prev_ins;
        spq_pkg::t_entry prev_entry;
        spq_pkg::t_entry next_entry;

        assign occupied = IDX < r_count;
        if (i == 0) begin : g_first
            assign prev_ins = 1'b0;
            assign prev_entry = ctl.new_entry;
        end else begin : g_inner
            assign prev_ins = cell_ins[i-1];
            assign prev_entry = cell_entry[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign next_entry = cell_entry[i];
        end else begin : g_body
            assign next_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (occupied),
            .i_prev_ins  (prev_ins),
            .i_prev_entry(prev_entry),
            .i_next_entry(next_entry),
            .o_entry     (cell_entry[i]),
            .o_ins       (cell_ins[i])
        );
    end

    always_comb begin
        n_count = r_count;
        n_status = spq_pkg::ST_DONE;
        n_head = '0;
        if (i_command == spq_pkg::CMD_ENQ) begin
            if (full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_head = cell_entry[0];
                n_count = r_count - 1'b1;
            end
        end
    end

    assign n_count_ext = CMPW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_head <= n_head;
            r_occupancy <= n_count_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_status;
    assign o_head_data = r_head.data;
    assign o_head_priority = r_head.prio;
    assign o_occupancy = r_occupancy;

endmodule
